// File: rtl/core/amdemod_pkg.sv
// Shared constants, codes and cosine table functions for the AM demodulator datapath.
`default_nettype none

package amdemod_pkg;

  // Default sizes.
  localparam int unsigned COS_TABLE_BITS  = 10;
  localparam int unsigned MAX_DECIM_SHIFT = 15;

  // Fixed field widths.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned SHIFT_W  = 4;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_SHIFT = 2'd1;
  localparam logic [1:0] REG_STEP  = 2'd2;
  localparam logic [1:0] REG_GAIN  = 2'd3;

  // Demodulator modes.
  localparam logic [MODE_W-1:0] MODE_MIX   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DECIM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PEAK  = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

  // Operation carried down the pipeline with each word.
  typedef enum logic [1:0] {
    OP_PASS,
    OP_MIX,
    OP_GAIN
  } op_e;

  // Pi in Q30 and one in Q30.
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  // Nine-term Taylor series of cos(x), x in Q30, truncating each term.
  function automatic logic [63:0] series_cos(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sum;
    x2  = (x * x) >> 30;
    t   = ONE_Q30;
    sum = t;
    t = ((t * x2) >> 30) / 64'd2;   sum = sum - t;
    t = ((t * x2) >> 30) / 64'd12;  sum = sum + t;
    t = ((t * x2) >> 30) / 64'd30;  sum = sum - t;
    t = ((t * x2) >> 30) / 64'd56;  sum = sum + t;
    t = ((t * x2) >> 30) / 64'd90;  sum = sum - t;
    t = ((t * x2) >> 30) / 64'd132; sum = sum + t;
    t = ((t * x2) >> 30) / 64'd182; sum = sum - t;
    t = ((t * x2) >> 30) / 64'd240; sum = sum + t;
    return sum;
  endfunction

  // Nine-term Taylor series of sin(x), x in Q30, truncating each term.
  function automatic logic [63:0] series_sin(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sum;
    x2  = (x * x) >> 30;
    t   = x;
    sum = t;
    t = ((t * x2) >> 30) / 64'd6;   sum = sum - t;
    t = ((t * x2) >> 30) / 64'd20;  sum = sum + t;
    t = ((t * x2) >> 30) / 64'd42;  sum = sum - t;
    t = ((t * x2) >> 30) / 64'd72;  sum = sum + t;
    t = ((t * x2) >> 30) / 64'd110; sum = sum - t;
    t = ((t * x2) >> 30) / 64'd156; sum = sum + t;
    t = ((t * x2) >> 30) / 64'd210; sum = sum - t;
    t = ((t * x2) >> 30) / 64'd272; sum = sum + t;
    return sum;
  endfunction

  // Rounded Q15 magnitude of the first-quadrant cos or sin for entry r of a
  // table with 2^bits entries per turn. The magnitude is clamped to 1.0 so
  // that the caller can saturate after applying the quadrant sign.
  function automatic logic [15:0] quarter_mag(input int unsigned r, input int unsigned bits,
                                              input bit use_sin);
    logic [63:0] x;
    logic [63:0] v;
    logic [63:0] m;
    x = (64'(r) * PI_Q30 * 64'd2) >> bits;
    v = use_sin ? series_sin(x) : series_cos(x);
    m = (v + 64'd16384) >> 15;
    return (m > 64'd32768) ? 16'd32768 : m[15:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/am_mix_decimate_peak_demod.sv
// Top level of the AM demodulator: config registers, decimation, mixer and peak detector.
// A result word is carried through the stage 1 to stage 4 registers; stage 4 drives the output.
// Throughput: one sample per cycle unless the output stalls; the four-stage pipeline
// (input, table read, multiply, round and saturate) closes up bubbles under output stalls.
// Samples that produce no result (skipped by decimation, no peak, unused mode) leave no word.
// Reset: asynchronous, active low; clears registers to their defaults, phase, decimation
// count and peak window; the cosine table is constant and needs no initialization.
`default_nettype none

module am_mix_decimate_peak_demod #(
  parameter int unsigned COS_TABLE_BITS  = amdemod_pkg::COS_TABLE_BITS,
  parameter int unsigned MAX_DECIM_SHIFT = amdemod_pkg::MAX_DECIM_SHIFT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Input stream; tdata: in_sample[15:0].
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [amdemod_pkg::SAMPLE_W-1:0]  s_axis_tdata,
  // Output stream; tdata: out_sample[15:0].
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [amdemod_pkg::SAMPLE_W-1:0]       m_axis_tdata,
  // Configuration port.
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [amdemod_pkg::APB_AW-1:0]    paddr,
  input  wire logic [amdemod_pkg::APB_DW-1:0]    pwdata,
  output logic [amdemod_pkg::APB_DW-1:0]         prdata,
  output logic                                   pready
);

  localparam int unsigned Quarter = 2 ** (COS_TABLE_BITS - 2);
  localparam int unsigned CntW    = MAX_DECIM_SHIFT;
  localparam int unsigned ShW     = $clog2(MAX_DECIM_SHIFT + 1);
  localparam int unsigned SW      = amdemod_pkg::SAMPLE_W;
  localparam int unsigned PW      = amdemod_pkg::PHASE_W;
  localparam int unsigned ProdW   = 2 * SW + 1;

  // Configuration registers.
  logic [amdemod_pkg::MODE_W-1:0]  demod_mode_q;
  logic [amdemod_pkg::SHIFT_W-1:0] decim_shift_q;
  logic [PW-1:0]                   phase_step_q;
  logic [amdemod_pkg::GAIN_W-1:0]  peak_gain_q;
  logic                            cfg_wr;
  logic [1:0]                      cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      demod_mode_q  <= amdemod_pkg::MODE_MIX;
      decim_shift_q <= '0;
      phase_step_q  <= '0;
      peak_gain_q   <= amdemod_pkg::GAIN_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        amdemod_pkg::REG_MODE:  demod_mode_q  <= pwdata[amdemod_pkg::MODE_W-1:0];
        amdemod_pkg::REG_SHIFT: decim_shift_q <= pwdata[amdemod_pkg::SHIFT_W-1:0];
        amdemod_pkg::REG_STEP:  phase_step_q  <= pwdata[PW-1:0];
        amdemod_pkg::REG_GAIN:  peak_gain_q   <= pwdata[amdemod_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      amdemod_pkg::REG_MODE:  prdata = 32'(demod_mode_q);
      amdemod_pkg::REG_SHIFT: prdata = 32'(decim_shift_q);
      amdemod_pkg::REG_STEP:  prdata = phase_step_q;
      amdemod_pkg::REG_GAIN:  prdata = 32'(peak_gain_q);
      default:                prdata = '0;
    endcase
  end

  // Quarter-wave cosine and sine magnitude tables, built at elaboration.
  logic [15:0] cos_rom [Quarter];
  logic [15:0] sin_rom [Quarter];

  for (genvar k = 0; k < Quarter; k++) begin : g_rom
    localparam logic [15:0] CosMag = amdemod_pkg::quarter_mag(k, COS_TABLE_BITS, 1'b0);
    localparam logic [15:0] SinMag = amdemod_pkg::quarter_mag(k, COS_TABLE_BITS, 1'b1);
    assign cos_rom[k] = CosMag;
    assign sin_rom[k] = SinMag;
  end

  // Pipeline handshake: each stage loads when it is empty or its successor moves.
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic s_fire;

  assign rdy4          = !v4_q || m_axis_tready;
  assign rdy3          = !v3_q || rdy4;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Stage 1: decimation, phase update and peak decision on the accepted sample.
  logic [CntW-1:0]             decim_count_q, decim_count_d, cnt_masked, cnt_mask;
  logic [ShW-1:0]              sh_eff;
  logic [PW-1:0]               phase_acc_q, phase_acc_d;
  logic signed [SW-1:0]        older_q, older_d, middle_q, middle_d;
  logic [1:0]                  fill_q, fill_d;
  logic signed [SW-1:0]        in_sample;
  logic                        keep;
  logic                        emit;
  amdemod_pkg::op_e            op1_d, op1_q;
  logic signed [SW-1:0]        a1_d, a1_q;
  logic [COS_TABLE_BITS-1:0]   idx1_q;

  assign in_sample = $signed(s_axis_tdata);

  always_comb begin
    if (32'(decim_shift_q) > MAX_DECIM_SHIFT) begin
      sh_eff = ShW'(MAX_DECIM_SHIFT);
    end else begin
      sh_eff = ShW'(decim_shift_q);
    end
    for (int i = 0; i < CntW; i++) begin
      cnt_mask[i] = (i < int'(sh_eff));
    end
    cnt_masked = decim_count_q & cnt_mask;
    keep       = (cnt_masked == '0);
  end

  always_comb begin
    decim_count_d = decim_count_q;
    phase_acc_d   = phase_acc_q;
    older_d       = older_q;
    middle_d      = middle_q;
    fill_d        = fill_q;
    emit          = 1'b0;
    op1_d         = amdemod_pkg::OP_PASS;
    a1_d          = in_sample;
    case (demod_mode_q)
      amdemod_pkg::MODE_MIX, amdemod_pkg::MODE_DECIM: begin
        decim_count_d = (cnt_masked + CntW'(1)) & cnt_mask;
        emit          = keep;
        if (demod_mode_q == amdemod_pkg::MODE_MIX) begin
          op1_d = amdemod_pkg::OP_MIX;
          if (keep) begin
            phase_acc_d = phase_acc_q + phase_step_q;
          end
        end
      end
      amdemod_pkg::MODE_PEAK: begin
        emit     = (fill_q >= 2'd2) && (middle_q > older_q) && (middle_q > in_sample);
        op1_d    = amdemod_pkg::OP_GAIN;
        a1_d     = middle_q;
        older_d  = middle_q;
        middle_d = in_sample;
        if (fill_q < 2'd2) begin
          fill_d = fill_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decim_count_q <= '0;
      phase_acc_q   <= '0;
      older_q       <= '0;
      middle_q      <= '0;
      fill_q        <= '0;
      v1_q          <= 1'b0;
    end else begin
      if (s_fire) begin
        decim_count_q <= decim_count_d;
        phase_acc_q   <= phase_acc_d;
        older_q       <= older_d;
        middle_q      <= middle_d;
        fill_q        <= fill_d;
      end
      if (rdy1) begin
        v1_q <= s_fire && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      op1_q  <= op1_d;
      a1_q   <= a1_d;
      idx1_q <= phase_acc_d[PW-1 -: COS_TABLE_BITS];
    end
  end

  // Stage 2: table lookup with quadrant sign, or gain as the second operand.
  logic [1:0]                quad;
  logic [COS_TABLE_BITS-3:0] quad_pos;
  logic [15:0]               mag;
  logic signed [SW:0]        cos_val;
  logic signed [SW:0]        b2_d, b2_q;
  amdemod_pkg::op_e          op2_q;
  logic signed [SW-1:0]      a2_q;

  assign quad     = idx1_q[COS_TABLE_BITS-1 -: 2];
  assign quad_pos = idx1_q[COS_TABLE_BITS-3:0];

  always_comb begin
    mag = quad[0] ? sin_rom[quad_pos] : cos_rom[quad_pos];
    if (quad[0] ^ quad[1]) begin
      cos_val = -$signed({1'b0, mag});
    end else if (mag > 16'd32767) begin
      cos_val = 17'sd32767;
    end else begin
      cos_val = $signed({1'b0, mag});
    end
    if (op1_q == amdemod_pkg::OP_GAIN) begin
      b2_d = $signed({1'b0, peak_gain_q});
    end else begin
      b2_d = cos_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      op2_q <= op1_q;
      a2_q  <= a1_q;
      b2_q  <= b2_d;
    end
  end

  // Stage 3: signed product.
  amdemod_pkg::op_e          op3_q;
  logic signed [SW-1:0]      a3_q;
  logic signed [ProdW-1:0]   p3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      op3_q <= op2_q;
      a3_q  <= a2_q;
      p3_q  <= ProdW'(a2_q) * ProdW'(b2_q);
    end
  end

  // Stage 4: round half up and saturate the product, or pass the sample through, and hold the output word.
  logic signed [ProdW:0]   rnd_sum;
  logic signed [ProdW:0]   rnd_shifted;
  logic signed [SW-1:0]    result;
  logic [SW-1:0]           out_q;

  always_comb begin
    if (op3_q == amdemod_pkg::OP_MIX) begin
      rnd_sum     = (ProdW+1)'(p3_q) + (ProdW+1)'(16384);
      rnd_shifted = rnd_sum >>> 15;
    end else begin
      rnd_sum     = (ProdW+1)'(p3_q) + (ProdW+1)'(128);
      rnd_shifted = rnd_sum >>> 8;
    end
    if (op3_q == amdemod_pkg::OP_PASS) begin
      result = a3_q;
    end else if (rnd_shifted > (ProdW+1)'(32767)) begin
      result = 16'sh7FFF;
    end else if (rnd_shifted < -(ProdW+1)'(32768)) begin
      result = 16'sh8000;
    end else begin
      result = rnd_shifted[SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire
